// ===== design/bthin_pkg.sv =====
// Shared types and constants of the binary image thinning block.
`timescale 1ns / 1ps
`default_nettype none
package bthin_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int CFG_W          = 9;
	localparam int PASS_W         = 16;
	localparam int NB_LAST        = 8;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_RUN   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_EVAL,
		S_CLR_RD,
		S_CLR_WR,
		S_SUB_END,
		S_PASS_END,
		S_DONE
	} state_t;

	typedef struct packed {
		logic host_sel;
		logic host_acc;
		logic init_run;
		logic init_sub;
		logic scan;
		logic eval;
		logic clr_rd;
		logic clr_wr;
		logic sub_end;
		logic pass_end;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic interior;
		logic k_done;
		logic last_px;
		logic any_next;
		logic phase;
		logic changed;
	} status_t;

endpackage
`default_nettype wire

// ===== design/binary_image_thinning.sv =====
// Top level of the binary image thinning block.
`timescale 1ns / 1ps
`default_nettype none
// Binary image thinning (Zhang-Suen, no destaircasing) over a one-bit image
// store of MAX_WIDTH x MAX_HEIGHT pixels. Commands transfer on start while
// busy is low: op 0 writes pixel_in at (col, row), op 2 reads it, op 1 thins
// the configured area to convergence. Every command returns exactly one
// result, shown for one cycle with done high; the receiver cannot stall, so
// take it in that cycle. Writes and reads can follow back to back; their
// result appears the cycle after the transfer. A run raises busy until it
// ends. Each sub-iteration visits every interior pixel (nine neighbor reads
// through the single image read port, the test and the mark write), then,
// when anything was marked, a clear sweep zeroes the marked pixels; a pass
// is two sub-iterations. With a run's result, pass_count holds the number of
// passes, counting the final one that removed nothing, saturating at 65535.
// Configuration (image_width index 0, image_height index 1) is written
// through cfg_write; the user must do so only while idle (the block does not
// enforce it). The whole configured area must be written before a run.
module binary_image_thinning #(
	parameter int MAX_WIDTH  = bthin_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bthin_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write,
	input  wire logic                        cfg_index,
	input  wire logic [bthin_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                        start,
	output logic                             busy,
	input  wire logic [1:0]                  op,
	input  wire logic [7:0]                  col,
	input  wire logic [7:0]                  row,
	input  wire logic                        pixel_in,
	output logic                             done,
	output logic                             pixel_out,
	output logic [bthin_pkg::PASS_W-1:0]     pass_count
);
	import bthin_pkg::*;

	cmd_t    cmd;
	status_t st;

	// Sequencer: owns the state machine, issues one command set per cycle
	bthin_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.st     (st),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Datapath: stores, counters, window test and result path
	bthin_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.op         (op),
		.col        (col),
		.row        (row),
		.pixel_in   (pixel_in),
		.done       (done),
		.pixel_out  (pixel_out),
		.pass_count (pass_count)
	);
endmodule
`default_nettype wire

// ===== design/bthin_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bthin_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== design/bthin_ctrl.sv =====
// Sequencer of the thinning block: host commands, scan, clear and pass control.
`timescale 1ns / 1ps
`default_nettype none
module bthin_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [1:0]         op,
	input  wire bthin_pkg::status_t st,
	output logic                    busy,
	output bthin_pkg::cmd_t         cmd
);
	import bthin_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && op == OP_RUN) state_nx = S_START;
			end
			S_START:    state_nx = st.interior ? S_SCAN : S_PASS_END;
			S_SCAN: begin
				if (st.k_done) state_nx = S_EVAL;
			end
			S_EVAL: begin
				if (st.last_px) state_nx = st.any_next ? S_CLR_RD : S_SUB_END;
				else state_nx = S_SCAN;
			end
			S_CLR_RD:   state_nx = S_CLR_WR;
			S_CLR_WR:   state_nx = st.last_px ? S_SUB_END : S_CLR_RD;
			S_SUB_END:  state_nx = st.phase ? S_PASS_END : S_SCAN;
			S_PASS_END: state_nx = st.changed ? S_SCAN : S_DONE;
			S_DONE:     state_nx = S_IDLE;
			default:    state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		busy     = 1'b1;
		case (state_q)
			S_IDLE: begin
				busy         = 1'b0;
				cmd.host_sel = 1'b1;
				cmd.host_acc = start && op != OP_RUN;
			end
			S_START: begin
				cmd.init_run = 1'b1;
				cmd.init_sub = 1'b1;
			end
			S_SCAN:     cmd.scan     = 1'b1;
			S_EVAL:     cmd.eval     = 1'b1;
			S_CLR_RD:   cmd.clr_rd   = 1'b1;
			S_CLR_WR:   cmd.clr_wr   = 1'b1;
			S_SUB_END:  cmd.sub_end  = 1'b1;
			S_PASS_END: cmd.pass_end = 1'b1;
			S_DONE:     cmd.done     = 1'b1;
			default:    busy         = 1'b1;
		endcase
	end

`ifndef SYNTH
	a_run_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && start && op == OP_RUN) |=> busy)
		else $error("run accepted but block not busy");
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.done |=> !busy)
		else $error("block stays busy after run result");
	a_scan_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START && st.interior) |=> cmd.scan)
		else $error("scan did not follow run start");
`endif
endmodule
`default_nettype wire

// ===== design/bthin_dp.sv =====
// Datapath: image and mark stores, scan counters, pixel test, pass counter.
`timescale 1ns / 1ps
`default_nettype none
module bthin_dp #(
	parameter int MAX_WIDTH  = bthin_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bthin_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bthin_pkg::cmd_t                cmd,
	output bthin_pkg::status_t                  st,
	input  wire logic                           cfg_write,
	input  wire logic                           cfg_index,
	input  wire logic [bthin_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic [1:0]                     op,
	input  wire logic [7:0]                     col,
	input  wire logic [7:0]                     row,
	input  wire logic                           pixel_in,
	output logic                                done,
	output logic                                pixel_out,
	output logic [bthin_pkg::PASS_W-1:0]        pass_count
);
	import bthin_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int XW    = $clog2(MAX_WIDTH);
	localparam int YW    = $clog2(MAX_HEIGHT);
	localparam int DWX   = $clog2(MAX_WIDTH + 1);
	localparam int DWY   = $clog2(MAX_HEIGHT + 1);
	localparam int DW0   = DWX > DWY ? DWX : DWY;
	localparam int DW    = DW0 > CFG_W ? DW0 : CFG_W;
	localparam int HW    = DW > 8 ? DW : 8;

	logic [CFG_W-1:0]  width_q, height_q;
	logic [DW-1:0]     eff_w, eff_h;
	logic [XW-1:0]     x_q, x_last;
	logic [YW-1:0]     y_q, y_last;
	logic [3:0]        k_q;
	logic [NB_LAST:0]  nb_q;
	logic              any_q, phase_q, changed_q;
	logic [PASS_W-1:0] passes_q;
	logic              res_s1, rd_s1;
	logic [XW-1:0]     nx;
	logic [YW-1:0]     ny;
	logic [AW-1:0]     host_addr, cur_addr, nb_addr;
	logic              host_in;
	logic              img_we, img_wd, img_rd;
	logic [AW-1:0]     img_wa, img_ra;
	logic              mark_rd;
	logic [7:0]        ring;
	logic [3:0]        cnt, rises;
	logic              ok;
	logic              adv_wrap;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W'(256);
			height_q <= CFG_W'(256);
		end else if (cfg_write) begin
			if (cfg_index == REG_WIDTH) width_q <= cfg_data;
			else height_q <= cfg_data;
		end
	end

	assign eff_w  = (DW'(width_q) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(width_q);
	assign eff_h  = (DW'(height_q) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(height_q);
	assign x_last = XW'(eff_w - DW'(2));
	assign y_last = YW'(eff_h - DW'(2));

	// Host addressing
	assign host_in   = HW'(col) < HW'(MAX_WIDTH) && HW'(row) < HW'(MAX_HEIGHT);
	assign host_addr = AW'(row) * AW'(MAX_WIDTH) + AW'(col);
	assign cur_addr  = AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q);

	// Neighbor coordinates for scan step k: center, then N clockwise to NW
	always_comb begin
		nx = x_q;
		ny = y_q;
		case (k_q)
			4'd1: ny = y_q - YW'(1);
			4'd2: begin nx = x_q + XW'(1); ny = y_q - YW'(1); end
			4'd3: nx = x_q + XW'(1);
			4'd4: begin nx = x_q + XW'(1); ny = y_q + YW'(1); end
			4'd5: ny = y_q + YW'(1);
			4'd6: begin nx = x_q - XW'(1); ny = y_q + YW'(1); end
			4'd7: nx = x_q - XW'(1);
			4'd8: begin nx = x_q - XW'(1); ny = y_q - YW'(1); end
			default: nx = x_q;
		endcase
	end
	assign nb_addr = AW'(ny) * AW'(MAX_WIDTH) + AW'(nx);

	// Store ports
	always_comb begin
		img_we = 1'b0;
		img_wa = host_addr;
		img_wd = pixel_in;
		if (cmd.host_acc && op == OP_WRITE && host_in) begin
			img_we = 1'b1;
		end else if (cmd.clr_wr && mark_rd) begin
			img_we = 1'b1;
			img_wa = cur_addr;
			img_wd = 1'b0;
		end
	end
	assign img_ra = cmd.host_sel ? host_addr : nb_addr;

	bthin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_image (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_wa),
		.wdata (img_wd),
		.raddr (img_ra),
		.rdata (img_rd)
	);

	bthin_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_marks (
		.clk   (clk),
		.we    (cmd.eval),
		.waddr (cur_addr),
		.wdata (ok),
		.raddr (cur_addr),
		.rdata (mark_rd)
	);

	// Pixel test on the gathered window
	assign ring = nb_q[NB_LAST:1];
	always_comb begin
		cnt   = '0;
		rises = '0;
		for (int i = 0; i < NB_LAST; i++) begin
			cnt   = cnt + 4'(ring[i]);
			rises = rises + 4'(!ring[i] && ring[(i + 1) % NB_LAST]);
		end
		ok = nb_q[0] && cnt >= 4'd2 && cnt <= 4'd6 && rises == 4'd1;
		if (!phase_q) begin
			ok = ok && !(ring[0] && ring[2] && ring[4]) && !(ring[2] && ring[4] && ring[6]);
		end else begin
			ok = ok && !(ring[0] && ring[2] && ring[6]) && !(ring[0] && ring[4] && ring[6]);
		end
	end

	assign adv_wrap = x_q == x_last && y_q == y_last;

	// Scan counters and run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= XW'(1);
			y_q       <= YW'(1);
			k_q       <= '0;
			nb_q      <= '0;
			any_q     <= 1'b0;
			phase_q   <= 1'b0;
			changed_q <= 1'b0;
			passes_q  <= '0;
			res_s1    <= 1'b0;
			rd_s1     <= 1'b0;
		end else begin
			res_s1 <= cmd.host_acc;
			rd_s1  <= cmd.host_acc && op == OP_READ && host_in;
			if (cmd.init_run) begin
				passes_q  <= '0;
				changed_q <= 1'b0;
				phase_q   <= 1'b0;
			end
			if (cmd.init_sub || cmd.sub_end) begin
				x_q   <= XW'(1);
				y_q   <= YW'(1);
				k_q   <= '0;
				any_q <= 1'b0;
			end
			if (cmd.sub_end) begin
				phase_q   <= !phase_q;
				changed_q <= changed_q || any_q;
			end
			if (cmd.pass_end) begin
				changed_q <= 1'b0;
				if (passes_q != '1) passes_q <= passes_q + PASS_W'(1);
			end
			if (cmd.scan) begin
				k_q <= k_q + 4'd1;
				if (k_q != 4'd0) nb_q[k_q - 4'd1] <= img_rd;
			end
			if (cmd.eval) begin
				any_q <= any_q || ok;
				k_q   <= '0;
			end
			if (cmd.eval || cmd.clr_wr) begin
				if (x_q == x_last) begin
					x_q <= XW'(1);
					y_q <= adv_wrap ? YW'(1) : y_q + YW'(1);
				end else begin
					x_q <= x_q + XW'(1);
				end
			end
		end
	end

	assign st.interior = eff_w >= DW'(3) && eff_h >= DW'(3);
	assign st.k_done   = k_q == 4'(NB_LAST + 1);
	assign st.last_px  = adv_wrap;
	assign st.any_next = any_q || ok;
	assign st.phase    = phase_q;
	assign st.changed  = changed_q;

	assign done       = res_s1 || cmd.done;
	assign pixel_out  = rd_s1 && img_rd;
	assign pass_count = cmd.done ? passes_q : '0;

`ifndef SYNTH
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= 4'(NB_LAST + 2))
		else $error("window step counter overran");
	a_scan_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan || cmd.eval) |-> (x_q >= XW'(1) && x_q <= x_last && y_q >= YW'(1)))
		else $error("scan outside interior");
	a_no_result_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_s1 && cmd.done))
		else $error("host and run results collide");
`endif
endmodule
`default_nettype wire
